### sv/knn_idw_pkg.sv
package knn_idw_pkg;

    // fixed widths of the item fields and of the weighting datapath
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = 17;
    localparam int SQ_W      = 32;
    localparam int DIST_W    = 33;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 17;
    localparam int MUL_W     = 50;
    localparam int PROD_W    = 66;
    localparam int DEN_W     = 68;
    localparam int NUM_W     = 84;
    localparam int VOLT_W    = 16;
    localparam int SAMPLE_W  = 24;
    localparam int IDX_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int DIV_STEPS = 16;
    localparam int TDATA_W   = 64;
    localparam int PADDR_W   = 4;

    // the weighting sequence is built for three neighbours
    localparam int NEIGHBOURS = 3;

    localparam logic [VOLT_W-1:0] VOLT_CEIL = 16'd65529;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX_RESET = 24'h7FFFFF;

    localparam logic [1:0] OP_POS    = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] REG_COUNT = 2'd0;
    localparam logic [1:0] REG_MIN   = 2'd1;
    localparam logic [1:0] REG_MAX   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DRAIN,
        ST_TERM,
        ST_DIV,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

### sv/knn_inverse_distance_interpolator.sv
// Keeps electrode positions (Q1.14) and normalised voltages (Q0.16) in two memories with
// separate read and write ports and answers queries with the inverse squared distance
// average over the three nearest active electrodes, exact to the truncated Q0.16
// quotient. Every item gives one result item. A position write is decoded and written;
// a sample write within the range also runs the shared restoring divider, and a query
// over n active electrodes scans them, reading one position a cycle, drains the
// distance pipeline, builds the cross products on one shared 33x17 multiplier and runs
// the divider. Voltage entries carry one valid bit each, cleared at reset, so no
// clearing pass is needed; positions must be written before use.
module knn_inverse_distance_interpolator #(
    parameter int MAX_ELECTRODES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // electrode_index, coord_x, coord_y, raw_sample, zero pad
    input  logic [knn_idw_pkg::TDATA_W-1:0]     s_axis_tdata,
    // op
    input  logic [1:0]                          s_axis_tuser,
    // stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // interp_value
    output logic [knn_idw_pkg::VOLT_W-1:0]      m_axis_tdata,
    // valid_res
    output logic [0:0]                          m_axis_tuser,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [knn_idw_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int ADDR_W = $clog2(MAX_ELECTRODES);
    localparam int CNT_W  = $clog2(MAX_ELECTRODES + 1);
    localparam int CMP_W  = (CNT_W > knn_idw_pkg::COUNT_W) ? CNT_W : knn_idw_pkg::COUNT_W;
    localparam int NB_W   = $clog2(knn_idw_pkg::NEIGHBOURS);

    localparam int COORD_W  = knn_idw_pkg::COORD_W;
    localparam int DIFF_W   = knn_idw_pkg::DIFF_W;
    localparam int SQ_W     = knn_idw_pkg::SQ_W;
    localparam int DIST_W   = knn_idw_pkg::DIST_W;
    localparam int MUL_A_W  = knn_idw_pkg::MUL_A_W;
    localparam int MUL_B_W  = knn_idw_pkg::MUL_B_W;
    localparam int MUL_W    = knn_idw_pkg::MUL_W;
    localparam int PROD_W   = knn_idw_pkg::PROD_W;
    localparam int DEN_W    = knn_idw_pkg::DEN_W;
    localparam int NUM_W    = knn_idw_pkg::NUM_W;
    localparam int VOLT_W   = knn_idw_pkg::VOLT_W;
    localparam int SAMPLE_W = knn_idw_pkg::SAMPLE_W;
    localparam int IDX_W    = knn_idw_pkg::IDX_W;
    localparam int COUNT_W  = knn_idw_pkg::COUNT_W;
    localparam int NB       = knn_idw_pkg::NEIGHBOURS;

    knn_idw_pkg::state_t state_reg, state_next;

    // configuration
    logic [COUNT_W-1:0]         count_reg;
    logic signed [SAMPLE_W-1:0] smin_reg;
    logic signed [SAMPLE_W-1:0] smax_reg;
    logic                       cfg_we;

    // captured item
    logic [1:0]                 op_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic signed [COORD_W-1:0]  qx_reg;
    logic signed [COORD_W-1:0]  qy_reg;
    logic signed [SAMPLE_W-1:0] raw_reg;

    // memories
    logic                       pos_we, pos_re, vol_we, vol_re;
    logic [ADDR_W-1:0]          pos_raddr, vol_raddr, item_addr;
    logic [2*COORD_W-1:0]       pos_rdata;
    logic [VOLT_W-1:0]          vol_rdata;
    logic [MAX_ELECTRODES-1:0]  vvld_reg;
    logic                       vok_reg;

    // scan pipeline
    logic [ADDR_W-1:0]          scan_cnt_reg;
    logic                       s0_vld_reg, s1_vld_reg, s2_vld_reg;
    logic [ADDR_W-1:0]          s0_idx_reg, s1_idx_reg, s2_idx_reg;
    logic signed [DIFF_W-1:0]   s1_dx_reg, s1_dy_reg;
    logic [SQ_W-1:0]            s2_sqx_reg, s2_sqy_reg;
    logic signed [DIFF_W-1:0]   dx, dy;
    logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
    logic [DIST_W-1:0]          d_sum, d_new;

    // neighbour list, nearest first
    logic [DIST_W-1:0]          nb_d_reg [NB];
    logic [ADDR_W-1:0]          nb_i_reg [NB];
    logic [NB-1:0]              nb_fill_reg;
    logic [NB-1:0]              nb_lt;
    logic                       nb_ins;

    // weighting
    logic [1:0]                 term_reg;
    logic [2:0]                 ph_reg;
    logic [NB_W-1:0]            oth_j, oth_k;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_W-1:0]           mul_full;
    logic [MUL_W-1:0]           mul_reg;
    logic [PROD_W-1:0]          p_reg;
    logic [DEN_W-1:0]           den_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [VOLT_W-1:0]          v_eff;
    logic                       term_last;

    // divider
    logic [NUM_W-1:0]           rem_reg, dsh_reg;
    logic [VOLT_W-1:0]          q_reg, q_next;
    logic [3:0]                 div_cnt_reg;
    logic                       div_ge, div_last;

    // decode helpers
    logic [CMP_W-1:0]           n_eff;
    logic                       idx_ok, range_ok, scan_last, out_free;
    logic signed [SAMPLE_W:0]   s_num, s_den;

    // results
    logic [VOLT_W-1:0]          volt_reg;
    logic [VOLT_W-1:0]          res_val_reg;
    logic                       res_ok_reg;
    logic                       m_tvalid_reg;
    logic [VOLT_W-1:0]          m_tdata_reg;
    logic                       m_tuser_reg;

    knn_idw_ram #(
        .WIDTH (2*COORD_W),
        .DEPTH (MAX_ELECTRODES)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (item_addr),
        .wdata ({qy_reg, qx_reg}),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    knn_idw_ram #(
        .WIDTH (VOLT_W),
        .DEPTH (MAX_ELECTRODES)
    ) u_volt_ram (
        .clk   (clk),
        .we    (vol_we),
        .waddr (item_addr),
        .wdata (volt_reg),
        .re    (vol_re),
        .raddr (vol_raddr),
        .rdata (vol_rdata)
    );

    // ---------------- register port ----------------

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            knn_idw_pkg::REG_COUNT: prdata = {{(32-COUNT_W){1'b0}}, count_reg};
            knn_idw_pkg::REG_MIN:   prdata = {{(32-SAMPLE_W){smin_reg[SAMPLE_W-1]}}, smin_reg};
            knn_idw_pkg::REG_MAX:   prdata = {{(32-SAMPLE_W){smax_reg[SAMPLE_W-1]}}, smax_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // ---------------- decode helpers ----------------

    assign n_eff = (CMP_W'(count_reg) > CMP_W'(MAX_ELECTRODES)) ?
                   CMP_W'(MAX_ELECTRODES) : CMP_W'(count_reg);
    assign idx_ok    = CMP_W'(idx_reg) < CMP_W'(MAX_ELECTRODES);
    assign range_ok  = smax_reg > smin_reg;
    assign item_addr = ADDR_W'(idx_reg);
    assign scan_last = CMP_W'(scan_cnt_reg) == (n_eff - CMP_W'(1));
    assign out_free  = !m_tvalid_reg || m_axis_tready;
    assign s_num     = (SAMPLE_W+1)'(raw_reg) - (SAMPLE_W+1)'(smin_reg);
    assign s_den     = (SAMPLE_W+1)'(smax_reg) - (SAMPLE_W+1)'(smin_reg);

    // ---------------- distance pipeline ----------------

    assign dx = DIFF_W'(qx_reg) - DIFF_W'($signed(pos_rdata[COORD_W-1:0]));
    assign dy = DIFF_W'(qy_reg) - DIFF_W'($signed(pos_rdata[2*COORD_W-1:COORD_W]));
    assign sqx_full = s1_dx_reg * s1_dx_reg;
    assign sqy_full = s1_dy_reg * s1_dy_reg;
    assign d_sum = DIST_W'(s2_sqx_reg) + DIST_W'(s2_sqy_reg);
    // coincident point counts as one lsb away
    assign d_new = (d_sum == '0) ? DIST_W'(1) : d_sum;

    // equal distance goes ahead of the stored entry, so the later index wins
    always_comb
    begin
        for (int k = 0; k < NB; k++)
        begin
            nb_lt[k] = nb_fill_reg[k] && (d_new > nb_d_reg[k]);
        end
        nb_ins = s2_vld_reg && !nb_lt[NB-1];
    end

    // ---------------- weighting multiplier ----------------

    // term i takes the product of the other two distances
    assign oth_j = (term_reg == 2'd0) ? NB_W'(1) : NB_W'(0);
    assign oth_k = (term_reg == 2'd2) ? NB_W'(1) : NB_W'(2);
    assign v_eff = vok_reg ? vol_rdata : '0;
    assign term_last = (term_reg == 2'd2) && (ph_reg == 3'd5);

    always_comb
    begin
        case (ph_reg)
            3'd0:
            begin
                mul_a = nb_d_reg[oth_j];
                mul_b = nb_d_reg[oth_k][MUL_B_W-1:0];
            end
            3'd1:
            begin
                mul_a = nb_d_reg[oth_j];
                mul_b = MUL_B_W'(nb_d_reg[oth_k][DIST_W-1:MUL_B_W]);
            end
            3'd3:
            begin
                mul_a = p_reg[DIST_W-1:0];
                mul_b = MUL_B_W'(v_eff);
            end
            3'd4:
            begin
                mul_a = p_reg[PROD_W-1:DIST_W];
                mul_b = MUL_B_W'(v_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_full = MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    // ---------------- divider ----------------

    assign div_ge   = rem_reg >= dsh_reg;
    assign q_next   = {q_reg[VOLT_W-2:0], div_ge};
    assign div_last = div_cnt_reg == 4'(knn_idw_pkg::DIV_STEPS - 1);

    // ---------------- sequencer ----------------

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            knn_idw_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = knn_idw_pkg::ST_DECODE;
                end
            end
            knn_idw_pkg::ST_DECODE:
            begin
                unique case (op_reg)
                    knn_idw_pkg::OP_POS:
                        state_next = idx_ok ? knn_idw_pkg::ST_WRITE : knn_idw_pkg::ST_DONE;
                    knn_idw_pkg::OP_SAMPLE:
                    begin
                        if (!idx_ok || !range_ok)
                        begin
                            state_next = knn_idw_pkg::ST_DONE;
                        end
                        else if (s_num <= 0 || s_num >= s_den)
                        begin
                            state_next = knn_idw_pkg::ST_WRITE;
                        end
                        else
                        begin
                            state_next = knn_idw_pkg::ST_DIV;
                        end
                    end
                    knn_idw_pkg::OP_QUERY:
                    begin
                        if (n_eff < CMP_W'(NB) || !range_ok)
                        begin
                            state_next = knn_idw_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = knn_idw_pkg::ST_SCAN;
                        end
                    end
                    default: state_next = knn_idw_pkg::ST_DONE;
                endcase
            end
            knn_idw_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = knn_idw_pkg::ST_DRAIN;
                end
            end
            knn_idw_pkg::ST_DRAIN:
            begin
                if (!s0_vld_reg && !s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = knn_idw_pkg::ST_TERM;
                end
            end
            knn_idw_pkg::ST_TERM:
            begin
                if (term_last)
                begin
                    state_next = knn_idw_pkg::ST_DIV;
                end
            end
            knn_idw_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = (op_reg == knn_idw_pkg::OP_SAMPLE) ?
                                 knn_idw_pkg::ST_WRITE : knn_idw_pkg::ST_DONE;
                end
            end
            knn_idw_pkg::ST_WRITE:
            begin
                state_next = knn_idw_pkg::ST_DONE;
            end
            knn_idw_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = knn_idw_pkg::ST_IDLE;
                end
            end
            default: state_next = knn_idw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        pos_we        = 1'b0;
        vol_we        = 1'b0;
        pos_re        = 1'b0;
        vol_re        = 1'b0;
        pos_raddr     = scan_cnt_reg;
        vol_raddr     = nb_i_reg[term_reg[NB_W-1:0]];
        unique case (state_reg)
            knn_idw_pkg::ST_IDLE:  s_axis_tready = 1'b1;
            knn_idw_pkg::ST_SCAN:  pos_re = 1'b1;
            knn_idw_pkg::ST_TERM:  vol_re = (ph_reg == 3'd0);
            knn_idw_pkg::ST_WRITE:
            begin
                pos_we = (op_reg == knn_idw_pkg::OP_POS);
                vol_we = (op_reg == knn_idw_pkg::OP_SAMPLE);
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // ---------------- control registers ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= knn_idw_pkg::ST_IDLE;
            count_reg    <= '0;
            smin_reg     <= '0;
            smax_reg     <= knn_idw_pkg::SAMPLE_MAX_RESET;
            vvld_reg     <= '0;
            nb_fill_reg  <= '0;
            s0_vld_reg   <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            scan_cnt_reg <= '0;
            term_reg     <= '0;
            ph_reg       <= '0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (paddr[3:2])
                    knn_idw_pkg::REG_COUNT: count_reg <= pwdata[COUNT_W-1:0];
                    knn_idw_pkg::REG_MIN:   smin_reg  <= pwdata[SAMPLE_W-1:0];
                    knn_idw_pkg::REG_MAX:   smax_reg  <= pwdata[SAMPLE_W-1:0];
                    default:                count_reg <= count_reg;
                endcase
            end

            if (vol_we)
            begin
                vvld_reg[item_addr] <= 1'b1;
            end

            s0_vld_reg <= (state_reg == knn_idw_pkg::ST_SCAN);
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;

            if (state_reg == knn_idw_pkg::ST_DECODE)
            begin
                nb_fill_reg  <= '0;
                scan_cnt_reg <= '0;
                term_reg     <= '0;
                ph_reg       <= '0;
                div_cnt_reg  <= '0;
            end
            else
            begin
                if (nb_ins)
                begin
                    nb_fill_reg <= {nb_fill_reg[NB-2:0], 1'b1} | nb_fill_reg;
                end
                if (state_reg == knn_idw_pkg::ST_SCAN)
                begin
                    scan_cnt_reg <= scan_cnt_reg + ADDR_W'(1);
                end
                if (state_reg == knn_idw_pkg::ST_TERM)
                begin
                    if (ph_reg == 3'd5)
                    begin
                        ph_reg   <= '0;
                        term_reg <= term_reg + 2'd1;
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                if (state_reg == knn_idw_pkg::ST_DIV)
                begin
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                end
            end

            if (state_reg == knn_idw_pkg::ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------

    always_ff @(posedge clk)
    begin
        if (state_reg == knn_idw_pkg::ST_IDLE && s_axis_tvalid)
        begin
            op_reg  <= s_axis_tuser;
            idx_reg <= s_axis_tdata[5:0];
            qx_reg  <= s_axis_tdata[21:6];
            qy_reg  <= s_axis_tdata[37:22];
            raw_reg <= s_axis_tdata[61:38];
        end

        // scan pipeline
        s0_idx_reg <= scan_cnt_reg;
        s1_idx_reg <= s0_idx_reg;
        s1_dx_reg  <= dx;
        s1_dy_reg  <= dy;
        s2_idx_reg <= s1_idx_reg;
        s2_sqx_reg <= sqx_full[SQ_W-1:0];
        s2_sqy_reg <= sqy_full[SQ_W-1:0];

        // sorted insert, entries from the insertion point move one place down
        if (nb_ins)
        begin
            if (!nb_lt[0])
            begin
                nb_d_reg[0] <= d_new;
                nb_i_reg[0] <= s2_idx_reg;
            end
            for (int k = 1; k < NB; k++)
            begin
                if (!nb_lt[k])
                begin
                    if (nb_lt[k-1])
                    begin
                        nb_d_reg[k] <= d_new;
                        nb_i_reg[k] <= s2_idx_reg;
                    end
                    else
                    begin
                        nb_d_reg[k] <= nb_d_reg[k-1];
                        nb_i_reg[k] <= nb_i_reg[k-1];
                    end
                end
            end
        end

        if (state_reg == knn_idw_pkg::ST_DECODE)
        begin
            res_val_reg <= '0;
            res_ok_reg  <= (op_reg == knn_idw_pkg::OP_POS && idx_ok) ||
                           (op_reg == knn_idw_pkg::OP_SAMPLE && idx_ok && range_ok);
            den_reg     <= '0;
            num_reg     <= '0;
            if (s_num <= 0)
            begin
                volt_reg <= '0;
            end
            else
            begin
                volt_reg <= knn_idw_pkg::VOLT_CEIL;
            end
            // sample quotient: (num << 16) / den, num below den
            rem_reg <= NUM_W'(s_num[SAMPLE_W-1:0]) << VOLT_W;
            dsh_reg <= NUM_W'(s_den[SAMPLE_W-1:0]) << (VOLT_W - 1);
            q_reg   <= '0;
        end

        if (state_reg == knn_idw_pkg::ST_TERM)
        begin
            if (ph_reg == 3'd0)
            begin
                vok_reg <= vvld_reg[nb_i_reg[term_reg[NB_W-1:0]]];
            end
            case (ph_reg)
                3'd0, 3'd1, 3'd3, 3'd4: mul_reg <= mul_full;
                default:                mul_reg <= mul_reg;
            endcase
            case (ph_reg)
                3'd1: p_reg <= PROD_W'(mul_reg);
                3'd2: p_reg <= p_reg + (PROD_W'(mul_reg) << MUL_B_W);
                3'd3: den_reg <= den_reg + DEN_W'(p_reg);
                3'd4: num_reg <= num_reg + NUM_W'(mul_reg);
                3'd5: num_reg <= num_reg + (NUM_W'(mul_reg) << DIST_W);
                default: p_reg <= p_reg;
            endcase
            if (term_last)
            begin
                rem_reg <= num_reg + (NUM_W'(mul_reg) << DIST_W);
                dsh_reg <= NUM_W'(den_reg) << (VOLT_W - 1);
                q_reg   <= '0;
            end
        end

        if (state_reg == knn_idw_pkg::ST_DIV)
        begin
            rem_reg <= div_ge ? (rem_reg - dsh_reg) : rem_reg;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= q_next;
            if (div_last)
            begin
                if (op_reg == knn_idw_pkg::OP_SAMPLE)
                begin
                    volt_reg <= (q_next > knn_idw_pkg::VOLT_CEIL) ?
                                knn_idw_pkg::VOLT_CEIL : q_next;
                end
                else
                begin
                    res_val_reg <= q_next;
                    res_ok_reg  <= 1'b1;
                end
            end
        end

        if (state_reg == knn_idw_pkg::ST_DONE && out_free)
        begin
            m_tdata_reg <= res_val_reg;
            m_tuser_reg <= res_ok_reg;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == knn_idw_pkg::ST_SCAN |-> CMP_W'(scan_cnt_reg) < n_eff)
        else $error("scan address beyond active electrodes");

    a_list_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == knn_idw_pkg::ST_TERM |-> nb_fill_reg == {NB{1'b1}})
        else $error("neighbour list not full after scan");

    a_list_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == knn_idw_pkg::ST_TERM |->
            nb_d_reg[0] <= nb_d_reg[1] && nb_d_reg[1] <= nb_d_reg[2])
        else $error("neighbour list out of order");

    a_volt_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        vol_we |-> volt_reg <= knn_idw_pkg::VOLT_CEIL)
        else $error("stored voltage above ceiling");

endmodule

### sv/knn_idw_ram.sv
module knn_idw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
